// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/safs_pkg.sv -----
// shared types, constants and codes of the sprite atlas frame sequencer
package safs_pkg;

    localparam int FRAME_WIDTH  = 32;
    localparam int FRAME_HEIGHT = 32;

    localparam int FRAME_IDX_W = 10;
    localparam int SHEET_POS_W = 12;
    localparam int SHEET_W_W   = 13;
    localparam int TPF_W       = 16;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 32;
    localparam int ELAPSED_W   = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // serial divider, two quotient bits per cycle
    localparam int DIV_W      = 32;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CYCLES = DIV_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int FW_W  = $clog2(FRAME_WIDTH + 1);
    localparam int FH_W  = $clog2(FRAME_HEIGHT + 1);
    localparam int POS_W = FRAME_IDX_W + FW_W;
    localparam int TOP_RAW_W = POS_W + FH_W + 1;
    localparam int TOP_W = (TOP_RAW_W > COORD_W + 1) ? TOP_RAW_W : COORD_W + 1;

    localparam int OUT_W    = FRAME_IDX_W + 4 * COORD_W + COLOR_W;
    localparam int TDATA_W  = ((OUT_W + 7) / 8) * 8;
    localparam int S_TDATA_W = COLOR_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHEET_LEFT      = 3'd0,
        REG_SHEET_TOP       = 3'd1,
        REG_SHEET_WIDTH     = 3'd2,
        REG_FIRST_FRAME     = 3'd3,
        REG_LAST_FRAME      = 3'd4,
        REG_TICKS_PER_FRAME = 3'd5,
        REG_LOOP_ENABLE     = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_RESTART = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_STEP,
        BK_WRAP,
        BK_POS,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [SHEET_POS_W-1:0] sheet_left;
        logic [SHEET_POS_W-1:0] sheet_top;
        logic [SHEET_W_W-1:0]   sheet_width;
        logic [FRAME_IDX_W-1:0] first_frame;
        logic [FRAME_IDX_W-1:0] last_frame;
        logic [TPF_W-1:0]       ticks_per_frame;
        logic                   loop_enable;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [COLOR_W-1:0] tint;
    } qent_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quot;
        logic [DIVISOR_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic [COLOR_W-1:0]     draw_color;
        logic [COORD_W-1:0]     rect_bottom;
        logic [COORD_W-1:0]     rect_right;
        logic [COORD_W-1:0]     rect_top;
        logic [COORD_W-1:0]     rect_left;
        logic [FRAME_IDX_W-1:0] frame_index;
    } result_t;

endpackage

// ----- rtl/sprite_atlas_frame_sequencer_core.sv -----
// top level of the sprite atlas frame sequencer: ports, config registers, packing
//
//  channel  direction  payload
//  s_       in         tuser: command, tdata: tint_color
//  m_       out        tdata: frame_index, rect_left/top/right/bottom, draw_color
//  cfg_     in         cfg_index, cfg_wdata, write on cfg_wr_en
//
// a render tick makes three passes through the shared serial divider (elapsed /
// ticks, step mod span, atlas position / sheet width), plus dispatch and output
// load. a restart only clears the elapsed counter and skips the divider.
// reset is synchronous and active low; the two-entry input queue keeps taking
// transactions while a result waits in the output register.
module sprite_atlas_frame_sequencer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tint_color[31:0]
    input  logic [safs_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_index[9:0], rect_left[25:10], rect_top[41:26], rect_right[57:42],
    // rect_bottom[73:58], draw_color[105:74], zero pad above
    output logic [safs_pkg::TDATA_W-1:0]   m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [safs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [safs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import safs_pkg::*;

    cfg_t     cfg_reg;
    logic     q_valid;
    qent_t    q_entry;
    logic     q_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;
    result_t  m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sheet_left      <= '0;
            cfg_reg.sheet_top       <= '0;
            cfg_reg.sheet_width     <= SHEET_W_W'(256);
            cfg_reg.first_frame     <= '0;
            cfg_reg.last_frame      <= '0;
            cfg_reg.ticks_per_frame <= TPF_W'(1);
            cfg_reg.loop_enable     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_SHEET_LEFT:      cfg_reg.sheet_left      <= cfg_wdata[SHEET_POS_W-1:0];
                REG_SHEET_TOP:       cfg_reg.sheet_top       <= cfg_wdata[SHEET_POS_W-1:0];
                REG_SHEET_WIDTH:     cfg_reg.sheet_width     <= cfg_wdata[SHEET_W_W-1:0];
                REG_FIRST_FRAME:     cfg_reg.first_frame     <= cfg_wdata[FRAME_IDX_W-1:0];
                REG_LAST_FRAME:      cfg_reg.last_frame      <= cfg_wdata[FRAME_IDX_W-1:0];
                REG_TICKS_PER_FRAME: cfg_reg.ticks_per_frame <= cfg_wdata[TPF_W-1:0];
                REG_LOOP_ENABLE:     cfg_reg.loop_enable     <= cfg_wdata[0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    safs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    safs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    safs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {{(TDATA_W - OUT_W){1'b0}}, m_result};

endmodule

// ----- rtl/safs_front.sv -----
// front end: accepts input transactions, tags their kind and queues them
module safs_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [safs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    output logic                         q_valid,
    output safs_pkg::qent_t              q_entry,
    input  logic                         q_pop
);
    import safs_pkg::*;

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;
    qent_t             in_entry;

    assign s_tready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_entry  = mem_reg[rd_ptr_reg];

    always_comb begin
        in_entry.kind = kind_t'(s_tuser);
        in_entry.tint = s_tdata;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/safs_div.sv -----
// shared serial divider, two restoring steps per cycle
module safs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  safs_pkg::div_req_t req,
    output safs_pkg::div_rsp_t rsp
);
    import safs_pkg::*;
    `include "assert_macros.svh"

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_W-1:0]     dq_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIV_W-1:0]     dq_next;
    logic [DIVISOR_W-1:0] rem_next;

    always_comb begin
        logic [DIVISOR_W:0]   trial;
        logic [DIV_W-1:0]     q;
        logic [DIVISOR_W-1:0] r;
        q = dq_reg;
        r = rem_reg;
        for (int i = 0; i < 2; i++) begin
            trial = {r, q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                trial = trial - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
            r = trial[DIVISOR_W-1:0];
        end
        dq_next  = q;
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (busy_reg) begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dq_reg;
    assign rsp.rem  = rem_reg;

    `ASSERT_NEXT(a_div_finishes, aclk, aresetn, busy_reg && !req.start && count_reg == DIV_CNT_W'(DIV_CYCLES - 1), done_reg && !busy_reg)
    `ASSERT_IMPLY(a_div_done_idle, aclk, aresetn, done_reg, !busy_reg)
    `ASSERT_IMPLY(a_div_no_restart, aclk, aresetn, req.start, !busy_reg)

endmodule

// ----- rtl/safs_back.sv -----
// back end: elapsed counter, frame selection, rectangle math and output register
module safs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  safs_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  safs_pkg::qent_t     q_entry,
    output logic                q_pop,
    output safs_pkg::div_req_t  div_req,
    input  safs_pkg::div_rsp_t  div_rsp,
    output logic                m_valid,
    input  logic                m_ready,
    output safs_pkg::result_t   m_result
);
    import safs_pkg::*;
    `include "assert_macros.svh"

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic [DIV_W-1:0]       step_reg;
    logic [FRAME_IDX_W-1:0] frame_reg;
    logic [COLOR_W-1:0]     tint_reg;
    result_t                pend_reg;
    result_t                out_reg;
    logic                   out_valid_reg;

    logic [TPF_W-1:0]       tpf;
    logic [SHEET_W_W-1:0]   sw;
    logic                   backward;
    logic [FRAME_IDX_W-1:0] span;
    logic [FRAME_IDX_W-1:0] step_sel;
    logic [FRAME_IDX_W-1:0] frame_sel;
    logic [POS_W-1:0]       pos;
    logic [COORD_W:0]       left_wide;
    logic [TOP_W-1:0]       top_wide;
    logic [COORD_W-1:0]     left_sat;
    logic [COORD_W-1:0]     top_sat;
    logic [COORD_W:0]       right_wide;
    logic [COORD_W:0]       bottom_wide;
    result_t                pend_next;
    logic                   out_free;
    logic                   emit;

    assign tpf      = (cfg.ticks_per_frame == '0) ? TPF_W'(1) : cfg.ticks_per_frame;
    assign sw       = (cfg.sheet_width == '0) ? SHEET_W_W'(1) : cfg.sheet_width;
    assign backward = cfg.first_frame > cfg.last_frame;
    assign span     = backward ? cfg.first_frame - cfg.last_frame
                               : cfg.last_frame - cfg.first_frame;
    assign out_free = !out_valid_reg || m_ready;

    // frame selection from the step clamped to span, or with looping its remainder modulo span + 1
    always_comb begin
        if (cfg.loop_enable) begin
            step_sel = div_rsp.rem[FRAME_IDX_W-1:0];
        end else if (step_reg > DIV_W'(span)) begin
            step_sel = span;
        end else begin
            step_sel = step_reg[FRAME_IDX_W-1:0];
        end
        if (cfg.first_frame == cfg.last_frame) begin
            frame_sel = cfg.first_frame;
        end else if (backward) begin
            frame_sel = cfg.first_frame - step_sel;
        end else begin
            frame_sel = cfg.first_frame + step_sel;
        end
    end

    assign pos = POS_W'(frame_sel) * POS_W'(FRAME_WIDTH);

    // rectangle from the atlas division
    always_comb begin
        left_wide = (COORD_W + 1)'(cfg.sheet_left) + (COORD_W + 1)'(div_rsp.rem);
        top_wide  = TOP_W'(cfg.sheet_top)
                  + TOP_W'(div_rsp.quot[POS_W-1:0]) * TOP_W'(FRAME_HEIGHT);
        left_sat  = left_wide[COORD_W] ? {COORD_W{1'b1}} : left_wide[COORD_W-1:0];
        top_sat   = (|top_wide[TOP_W-1:COORD_W]) ? {COORD_W{1'b1}}
                                                 : top_wide[COORD_W-1:0];
        right_wide  = (COORD_W + 1)'(left_sat) + (COORD_W + 1)'(FRAME_WIDTH);
        bottom_wide = (COORD_W + 1)'(top_sat) + (COORD_W + 1)'(FRAME_HEIGHT);
        pend_next.frame_index = frame_reg;
        pend_next.rect_left   = left_sat;
        pend_next.rect_top    = top_sat;
        pend_next.rect_right  = right_wide[COORD_W] ? {COORD_W{1'b1}}
                                                    : right_wide[COORD_W-1:0];
        pend_next.rect_bottom = bottom_wide[COORD_W] ? {COORD_W{1'b1}}
                                                     : bottom_wide[COORD_W-1:0];
        pend_next.draw_color  = tint_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid && q_entry.kind == KIND_TICK) begin
                    state_next = BK_STEP;
                end
            end
            BK_STEP: begin
                if (div_rsp.done) begin
                    state_next = BK_WRAP;
                end
            end
            BK_WRAP: begin
                if (div_rsp.done) begin
                    state_next = BK_POS;
                end
            end
            BK_POS: begin
                if (div_rsp.done) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = elapsed_reg;
        div_req.divisor  = tpf;
        emit             = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                q_pop = q_valid;
                div_req.start = q_valid && q_entry.kind == KIND_TICK;
            end
            BK_STEP: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = div_rsp.quot;
                div_req.divisor  = DIVISOR_W'(span) + 1'b1;
            end
            BK_WRAP: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = DIV_W'(pos);
                div_req.divisor  = DIVISOR_W'(sw);
            end
            BK_EMIT: begin
                emit = out_free;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_IDLE && q_valid) begin
            tint_reg <= q_entry.tint;
        end
        if (state_reg == BK_STEP && div_rsp.done) begin
            step_reg <= div_rsp.quot;
        end
        if (state_reg == BK_WRAP && div_rsp.done) begin
            frame_reg <= frame_sel;
        end
        if (state_reg == BK_POS && div_rsp.done) begin
            pend_reg <= pend_next;
        end
        if (emit) begin
            out_reg <= pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_IDLE && q_valid && q_entry.kind == KIND_RESTART) begin
                elapsed_reg <= '0;
            end else if (emit && elapsed_reg != {ELAPSED_W{1'b1}}) begin
                elapsed_reg <= elapsed_reg + 1'b1;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    `ASSERT_NEXT(a_elapsed_sat, aclk, aresetn, elapsed_reg == {ELAPSED_W{1'b1}}, elapsed_reg == {ELAPSED_W{1'b1}} || elapsed_reg == '0)

endmodule

// ----- sim/frame_rect_checker.sv -----
// checker: mirrors the frame sequencer, predicts each source rectangle and compares results
module frame_rect_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [safs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [safs_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [safs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [safs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              rect_mismatches,
    output int                              rects_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import safs_pkg::*;

    cfg_t        sheet_cfg;
    logic [31:0] tick_count;
    result_t     rect_q[$];

    function automatic logic [15:0] clip16(input logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic result_t predict_rect(input logic [COLOR_W-1:0] tint);
        result_t     r;
        logic [31:0] tpf;
        logic [31:0] step;
        logic [31:0] span;
        logic [9:0]  frame;
        logic [63:0] sw;
        logic [63:0] pos;
        tpf  = (sheet_cfg.ticks_per_frame == '0) ? 32'd1 : 32'(sheet_cfg.ticks_per_frame);
        step = tick_count / tpf;
        if (sheet_cfg.first_frame == sheet_cfg.last_frame) begin
            frame = sheet_cfg.first_frame;
        end else begin
            span = (sheet_cfg.first_frame > sheet_cfg.last_frame)
                 ? 32'(sheet_cfg.first_frame) - 32'(sheet_cfg.last_frame)
                 : 32'(sheet_cfg.last_frame) - 32'(sheet_cfg.first_frame);
            if (sheet_cfg.loop_enable)
                step = step % (span + 32'd1);
            else if (step > span)
                step = span;
            // playback runs downward when the first frame sits above the last
            frame = (sheet_cfg.first_frame > sheet_cfg.last_frame)
                  ? sheet_cfg.first_frame - step[9:0]
                  : sheet_cfg.first_frame + step[9:0];
        end
        sw  = (sheet_cfg.sheet_width == '0) ? 64'd1 : 64'(sheet_cfg.sheet_width);
        pos = 64'(frame) * 64'(FRAME_WIDTH);
        r.frame_index = frame;
        r.rect_left   = clip16(64'(sheet_cfg.sheet_left) + pos % sw);
        r.rect_top    = clip16(64'(sheet_cfg.sheet_top) + (pos / sw) * 64'(FRAME_HEIGHT));
        r.rect_right  = clip16(64'(r.rect_left) + 64'(FRAME_WIDTH));
        r.rect_bottom = clip16(64'(r.rect_top) + 64'(FRAME_HEIGHT));
        r.draw_color  = tint;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            rect_mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    initial begin
        rect_mismatches   = 0;
        rects_outstanding = 0;
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            sheet_cfg.sheet_left      = '0;
            sheet_cfg.sheet_top       = '0;
            sheet_cfg.sheet_width     = 13'd256;
            sheet_cfg.first_frame     = '0;
            sheet_cfg.last_frame      = '0;
            sheet_cfg.ticks_per_frame = 16'd1;
            sheet_cfg.loop_enable     = 1'b0;
            tick_count = '0;
            rect_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[OUT_W-1:0]);
                if (rect_q.size() == 0) begin
                    rect_mismatches++;
                    $display("%0t: result transaction, expected none actual %h",
                             $time, m_tdata);
                end else begin
                    want = rect_q.pop_front();
                    check_field("frame_index", want.frame_index, got.frame_index);
                    check_field("rect_left", want.rect_left, got.rect_left);
                    check_field("rect_top", want.rect_top, got.rect_top);
                    check_field("rect_right", want.rect_right, got.rect_right);
                    check_field("rect_bottom", want.rect_bottom, got.rect_bottom);
                    check_field("draw_color", want.draw_color, got.draw_color);
                    check_field("tdata pad", '0, 32'(m_tdata[TDATA_W-1:OUT_W]));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SHEET_LEFT:      sheet_cfg.sheet_left      = cfg_wdata[SHEET_POS_W-1:0];
                    REG_SHEET_TOP:       sheet_cfg.sheet_top       = cfg_wdata[SHEET_POS_W-1:0];
                    REG_SHEET_WIDTH:     sheet_cfg.sheet_width     = cfg_wdata[SHEET_W_W-1:0];
                    REG_FIRST_FRAME:     sheet_cfg.first_frame     = cfg_wdata[FRAME_IDX_W-1:0];
                    REG_LAST_FRAME:      sheet_cfg.last_frame      = cfg_wdata[FRAME_IDX_W-1:0];
                    REG_TICKS_PER_FRAME: sheet_cfg.ticks_per_frame = cfg_wdata[TPF_W-1:0];
                    REG_LOOP_ENABLE:     sheet_cfg.loop_enable     = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (kind_t'(s_tuser) == KIND_RESTART) begin
                    tick_count = '0;
                end else begin
                    rect_q.push_back(predict_rect(s_tdata));
                    if (tick_count != '1)
                        tick_count = tick_count + 32'd1;
                end
            end
        end
        rects_outstanding <= rect_q.size();
    end

endmodule

// ----- sim/tb_sprite_atlas_frame_sequencer_core.sv -----
// testbench top: clock, reset, register settings, transaction stimulus and verdict
module tb_sprite_atlas_frame_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import safs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 500;
    localparam int RAND_PHASES  = 40;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  long_hold_req;

    int rect_mismatches;
    int rects_outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    sprite_atlas_frame_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    frame_rect_checker rect_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .rect_mismatches   (rect_mismatches),
        .rects_outstanding (rects_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random back-pressure plus one long hold on request
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // unused upper bits carry random junk, the block must mask them
    task automatic apply_setting(input cfg_t c);
        put_reg(REG_SHEET_LEFT, {4'($urandom), c.sheet_left});
        put_reg(REG_SHEET_TOP, {4'($urandom), c.sheet_top});
        put_reg(REG_SHEET_WIDTH, {3'($urandom), c.sheet_width});
        put_reg(REG_FIRST_FRAME, {6'($urandom), c.first_frame});
        put_reg(REG_LAST_FRAME, {6'($urandom), c.last_frame});
        put_reg(REG_TICKS_PER_FRAME, c.ticks_per_frame);
        put_reg(REG_LOOP_ENABLE, {15'($urandom), c.loop_enable});
        put_reg(REG_SPARE, 16'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic cfg_t make_setting(input int left, input int top, input int sw,
                                          input int first, input int last, input int tpf,
                                          input int loop_on);
        cfg_t c;
        c.sheet_left      = 12'(left);
        c.sheet_top       = 12'(top);
        c.sheet_width     = 13'(sw);
        c.first_frame     = 10'(first);
        c.last_frame      = 10'(last);
        c.ticks_per_frame = 16'(tpf);
        c.loop_enable     = 1'(loop_on);
        return c;
    endfunction

    function automatic cfg_t random_setting();
        cfg_t       c;
        logic [9:0] d;
        c.sheet_left = 12'($urandom);
        c.sheet_top  = 12'($urandom);
        case ($urandom_range(5))
            0:       c.sheet_width = '0;
            1:       c.sheet_width = 13'd1 << $urandom_range(12);
            2:       c.sheet_width = 13'($urandom_range(1, 4096));
            3:       c.sheet_width = 13'($urandom_range(4097, 8191));
            default: c.sheet_width = 13'($urandom_range(1, 300));
        endcase
        c.first_frame = 10'($urandom);
        d = 10'($urandom_range(0, 12));
        case ($urandom_range(3))
            0:       c.last_frame = 10'($urandom);
            1:       c.last_frame = c.first_frame - d;
            default: c.last_frame = c.first_frame + d;
        endcase
        case ($urandom_range(7))
            0:       c.ticks_per_frame = '0;
            1:       c.ticks_per_frame = 16'($urandom);
            2:       c.ticks_per_frame = 16'hFFFF;
            default: c.ticks_per_frame = 16'($urandom_range(1, 4));
        endcase
        c.loop_enable = 1'($urandom);
        return c;
    endfunction

    task automatic send_item(input kind_t kind, input logic [S_TDATA_W-1:0] tint);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= tint;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering, wait for every rectangle, then let trailing restarts finish
    task automatic settle();
        s_tvalid <= 1'b0;
        // outstanding count is registered, so it lags the last accepted transaction
        @(posedge aclk);
        while (rects_outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic play_ticks(input int n_ticks);
        send_item(KIND_RESTART, 32'($urandom));
        for (int i = 0; i < n_ticks; i++)
            send_item(KIND_TICK, (i % 2) ? 32'h0000_0000 : 32'hFFFF_FFFF);
        settle();
    endtask

    initial begin
        cfg_t setting;
        int   n_items;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = KIND_TICK;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SHEET_LEFT;
        cfg_wdata     = '0;
        long_hold_req = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 47;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings first, then corners: saturation, zero width and ticks, wrap, clamp
        play_ticks(2);
        apply_setting(make_setting(4095, 4095, 0, 1023, 0, 0, 0));
        play_ticks(3);
        apply_setting(make_setting(0, 0, 8191, 0, 1023, 65535, 1));
        play_ticks(2);
        apply_setting(make_setting(100, 200, 64, 5, 3, 2, 1));
        play_ticks(7);
        apply_setting(make_setting(0, 0, 4096, 3, 5, 1, 0));
        play_ticks(5);
        apply_setting(make_setting(4095, 0, 1, 7, 7, 3, 1));
        play_ticks(2);

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < RAND_PHASES / 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 47;
            end else if (p < 2 * RAND_PHASES / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            setting = random_setting();
            apply_setting(setting);
            if (p == RAND_PHASES - 5) begin
                long_hold_req <= 1'b1;
                @(posedge aclk);
                long_hold_req <= 1'b0;
            end
            n_items = $urandom_range(30, 52);
            for (int i = 0; i < n_items; i++)
                send_item(($urandom_range(99) < 6) ? KIND_RESTART : KIND_TICK, 32'($urandom));
            settle();
        end

        if (rect_mismatches == 0 && rects_outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sprite_atlas_frame_sequencer_core.f -----
+incdir+rtl
rtl/safs_pkg.sv
rtl/safs_front.sv
rtl/safs_div.sv
rtl/safs_back.sv
rtl/sprite_atlas_frame_sequencer_core.sv
sim/frame_rect_checker.sv
sim/tb_sprite_atlas_frame_sequencer_core.sv
